FILE: hw/rtl/imhpq_pkg.sv
// Shared constants, status codes and types of the indexed min-heap queue.
package imhpq_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int KEY_BITS     = 32;
    localparam int VTX_W        = 10;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int SLOT_W       = $clog2(MAX_VERTICES + 1);
    localparam int ENTRY_W      = VTX_W + KEY_BITS;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_EMPTY       = 3'd1;
    localparam logic [2:0] ST_FULL        = 3'd2;
    localparam logic [2:0] ST_PRESENT     = 3'd3;
    localparam logic [2:0] ST_NOT_PRESENT = 3'd4;
    localparam logic [2:0] ST_NOT_SMALLER = 3'd5;

    typedef logic [VTX_W-1:0]    t_vertex;
    typedef logic [KEY_BITS-1:0] t_key;
    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [ADDR_W-1:0]   t_addr;

    typedef struct packed {
        t_vertex vertex;
        t_key    key;
    } t_entry;

endpackage

FILE: hw/rtl/imhpq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module imhpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: hw/rtl/indexed_min_heap_priority_queue_unit.sv
// Indexed binary min-heap with insert, delete-minimum and decrease-key.
// One transaction at a time; each heap level is a read, compare and write of the heap RAM:
// sift-up reads the parent (S_SU, S_SU2), sift-down reads the left then the right child over one port
// (S_SD, S_SD2, S_SD3). A finished result waits in an output register.
// After reset the vertex-to-slot table is cleared one entry at a time; no input is taken meanwhile.
module indexed_min_heap_priority_queue_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_mode,
    input  logic [9:0]               i_vertex_id,
    input  logic [31:0]              i_key_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output imhpq_pkg::t_vertex       o_out_vertex,
    output logic [31:0]              o_out_key,
    output logic [2:0]               o_status,
    output logic [10:0]              o_entries_after
);
    import imhpq_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_LKP  = 4'd2;
    localparam logic [3:0] S_INSK = 4'd3;
    localparam logic [3:0] S_DECK = 4'd4;
    localparam logic [3:0] S_DL1  = 4'd5;
    localparam logic [3:0] S_DL2  = 4'd6;
    localparam logic [3:0] S_SU   = 4'd7;
    localparam logic [3:0] S_SU2  = 4'd8;
    localparam logic [3:0] S_SD   = 4'd9;
    localparam logic [3:0] S_SD2  = 4'd10;
    localparam logic [3:0] S_SD3  = 4'd11;
    localparam logic [3:0] S_FIN  = 4'd12;

    logic [3:0]  r_state, n_state;
    t_slot       r_cnt, n_cnt;
    t_slot       r_s, n_s;
    t_vertex     r_v, n_v;
    t_key        r_k, n_k;
    logic        r_dec, n_dec;
    logic        r_inr, n_inr;
    logic        r_hr, n_hr;
    t_entry      r_left, n_left;
    t_addr       r_clr, n_clr;
    t_vertex     r_rv, n_rv;
    t_key        r_rk, n_rk;
    logic [2:0]  r_st, n_st;
    logic        r_ovalid, n_ovalid;
    t_vertex     r_ov, n_ov;
    t_key        r_ok, n_ok;
    logic [2:0]  r_ost, n_ost;
    t_slot       r_oent, n_oent;

    logic        heap_we;
    t_addr       heap_waddr, heap_raddr;
    t_entry      heap_wdata, heap_rdata;
    logic        pos_we;
    t_addr       pos_waddr, pos_raddr;
    t_slot       pos_wdata, pos_rdata;

    logic [SLOT_W:0] c2;
    logic [SLOT_W:0] cnt_x;
    logic            pick_r;
    t_entry          child;
    t_slot           child_s;
    logic            present;

    imhpq_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_VERTICES)) u_heap (
        .i_clk   (i_clk),
        .i_we    (heap_we),
        .i_waddr (heap_waddr),
        .i_wdata (heap_wdata),
        .i_raddr (heap_raddr),
        .o_rdata (heap_rdata)
    );

    imhpq_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_VERTICES)) u_pos (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_ovalid;
    assign o_out_vertex    = r_ov;
    assign o_out_key       = r_ok;
    assign o_status        = r_ost;
    assign o_entries_after = r_oent;

    assign c2      = {r_s, 1'b0};
    assign cnt_x   = {1'b0, r_cnt};
    assign pick_r  = r_hr && (r_left.key > heap_rdata.key);
    assign child   = pick_r ? heap_rdata : r_left;
    assign child_s = pick_r ? SLOT_W'(c2 + 1'b1) : SLOT_W'(c2);
    assign present = r_inr && (pos_rdata != '0);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_s     = r_s;
        n_v     = r_v;
        n_k     = r_k;
        n_dec   = r_dec;
        n_inr   = r_inr;
        n_hr    = r_hr;
        n_left  = r_left;
        n_clr   = r_clr;
        n_rv    = r_rv;
        n_rk    = r_rk;
        n_st    = r_st;
        n_ov    = r_ov;
        n_ok    = r_ok;
        n_ost   = r_ost;
        n_oent  = r_oent;
        n_ovalid = r_ovalid && !i_out_ready;

        heap_we    = 1'b0;
        heap_waddr = ADDR_W'(r_s - 1'b1);
        heap_wdata = '{vertex: r_v, key: r_k};
        heap_raddr = '0;
        pos_we     = 1'b0;
        pos_waddr  = ADDR_W'(r_v);
        pos_wdata  = r_s;
        pos_raddr  = ADDR_W'(i_vertex_id);

        unique case (r_state)
            S_CLR: begin
                pos_we    = 1'b1;
                pos_waddr = r_clr;
                pos_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == ADDR_W'(MAX_VERTICES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_v   = i_vertex_id;
                    n_k   = i_key_value;
                    n_rv  = i_vertex_id;
                    n_dec = i_mode[1];
                    n_inr = (SLOT_W + 1)'(i_vertex_id) < (SLOT_W + 1)'(MAX_VERTICES);
                    if (!i_mode[1] && i_mode[0]) begin
                        if (r_cnt == '0) begin
                            n_rv    = '0;
                            n_rk    = '0;
                            n_st    = ST_EMPTY;
                            n_state = S_FIN;
                        end else begin
                            n_state = S_DL1;
                        end
                    end else begin
                        n_state = S_LKP;
                    end
                end
            end
            S_LKP: begin
                heap_raddr = ADDR_W'(pos_rdata - 1'b1);
                n_s        = pos_rdata;
                n_rk       = '0;
                if (r_dec) begin
                    if (!present) begin
                        n_st    = ST_NOT_PRESENT;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_DECK;
                    end
                end else if (!r_inr) begin
                    n_st    = ST_FULL;
                    n_state = S_FIN;
                end else if (present) begin
                    n_state = S_INSK;
                end else if (r_cnt == SLOT_W'(MAX_VERTICES)) begin
                    n_st    = ST_FULL;
                    n_state = S_FIN;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_s     = r_cnt + 1'b1;
                    n_rk    = r_k;
                    n_st    = ST_OK;
                    n_state = S_SU;
                end
            end
            S_INSK: begin
                n_st    = ST_PRESENT;
                n_rk    = heap_rdata.key;
                n_state = S_FIN;
            end
            S_DECK: begin
                if (r_k >= heap_rdata.key) begin
                    n_st    = ST_NOT_SMALLER;
                    n_rk    = heap_rdata.key;
                    n_state = S_FIN;
                end else begin
                    n_st    = ST_OK;
                    n_rk    = r_k;
                    n_state = S_SU;
                end
            end
            S_DL1: begin
                n_rv       = heap_rdata.vertex;
                n_rk       = heap_rdata.key;
                n_st       = ST_OK;
                heap_raddr = ADDR_W'(r_cnt - 1'b1);
                n_state    = S_DL2;
            end
            S_DL2: begin
                // drop the removed vertex from the slot table
                pos_we    = 1'b1;
                pos_waddr = ADDR_W'(r_rv);
                pos_wdata = '0;
                n_cnt     = r_cnt - 1'b1;
                n_v       = heap_rdata.vertex;
                n_k       = heap_rdata.key;
                n_s       = SLOT_W'(1);
                n_state   = (r_cnt == SLOT_W'(1)) ? S_FIN : S_SD;
            end
            S_SU: begin
                heap_raddr = ADDR_W'((r_s >> 1) - 1'b1);
                if (r_s == SLOT_W'(1)) begin
                    heap_we = 1'b1;
                    pos_we  = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_state = S_SU2;
                end
            end
            S_SU2: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                if (heap_rdata.key > r_k) begin
                    // move the parent down into this slot
                    heap_wdata = heap_rdata;
                    pos_waddr  = ADDR_W'(heap_rdata.vertex);
                    n_s        = r_s >> 1;
                    n_state    = S_SU;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SD: begin
                heap_raddr = ADDR_W'(c2 - 1'b1);
                if (c2 > cnt_x) begin
                    heap_we = 1'b1;
                    pos_we  = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_state = S_SD2;
                end
            end
            S_SD2: begin
                n_left     = heap_rdata;
                n_hr       = c2 < cnt_x;
                heap_raddr = ADDR_W'(c2);
                n_state    = S_SD3;
            end
            S_SD3: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                if (r_k > child.key) begin
                    // lift the smaller child into this slot
                    heap_wdata = child;
                    pos_waddr  = ADDR_W'(child.vertex);
                    n_s        = child_s;
                    n_state    = S_SD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    n_ov     = r_rv;
                    n_ok     = r_rk;
                    n_ost    = r_st;
                    n_oent   = r_cnt;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_cnt    <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
        r_s    <= n_s;
        r_v    <= n_v;
        r_k    <= n_k;
        r_dec  <= n_dec;
        r_inr  <= n_inr;
        r_hr   <= n_hr;
        r_left <= n_left;
        r_rv   <= n_rv;
        r_rk   <= n_rk;
        r_st   <= n_st;
        r_ov   <= n_ov;
        r_ok   <= n_ok;
        r_ost  <= n_ost;
        r_oent <= n_oent;
    end
endmodule

FILE: dv/tb_indexed_min_heap_priority_queue_unit.sv
// Self-checking testbench of the indexed min-heap queue: random and directed operations.
module tb_indexed_min_heap_priority_queue_unit;
    import imhpq_pkg::*;

    localparam logic [1:0] MODE_DECREASE = 2'd2;
    localparam logic [1:0] MODE_ALIAS    = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [9:0]  vertex;
        logic [31:0] key;
    } t_op;

    typedef struct packed {
        logic [9:0]  vertex;
        logic [31:0] key;
        logic [2:0]  status;
        logic [10:0] entries;
    } t_res;

    logic        i_clk, i_rst_n;
    logic        i_in_valid, i_out_ready;
    logic [1:0]  i_mode;
    logic [9:0]  i_vertex_id;
    logic [31:0] i_key_value;
    logic        o_in_ready, o_out_valid;
    t_vertex     o_out_vertex;
    logic [31:0] o_out_key;
    logic [2:0]  o_status;
    logic [10:0] o_entries_after;

    indexed_min_heap_priority_queue_unit DUT (.*);

    // predictor state
    logic [9:0]  hp_slot [1:MAX_VERTICES];
    logic [10:0] hp_pos [0:MAX_VERTICES-1];
    logic [31:0] hp_key [0:MAX_VERTICES-1];
    int          hp_count;

    t_op  pending_ops[$];
    t_res expected_results[$];
    int   errors = 0;
    bit   stim_done = 0;
    int   calm = 0;  // cycles without idling left

    function automatic void heap_swap(int a, int b);
        logic [9:0] va, vb;
        va = hp_slot[a];
        vb = hp_slot[b];
        hp_slot[a] = vb;
        hp_slot[b] = va;
        hp_pos[vb] = 11'(a);
        hp_pos[va] = 11'(b);
    endfunction

    function automatic void heap_up(int s);
        while (s > 1 && hp_key[hp_slot[s>>1]] > hp_key[hp_slot[s]]) begin
            heap_swap(s >> 1, s);
            s = s >> 1;
        end
    endfunction

    function automatic void heap_down(int s);
        int c;
        while (2*s <= hp_count) begin
            c = 2*s;
            if (c < hp_count && hp_key[hp_slot[c]] > hp_key[hp_slot[c+1]]) c++;
            if (!(hp_key[hp_slot[s]] > hp_key[hp_slot[c]])) break;
            heap_swap(s, c);
            s = c;
        end
    endfunction

    function automatic t_res heap_apply(t_op op);
        t_res r;
        logic [9:0] mv, lv;
        r = '0;
        r.vertex = op.vertex;
        if (op.mode[1]) begin
            if (hp_pos[op.vertex] == 0) r.status = ST_NOT_PRESENT;
            else if (op.key >= hp_key[op.vertex]) begin
                r.status = ST_NOT_SMALLER;
                r.key = hp_key[op.vertex];
            end else begin
                hp_key[op.vertex] = op.key;
                r.key = op.key;
                heap_up(int'(hp_pos[op.vertex]));
            end
        end else if (op.mode[0]) begin
            r.vertex = '0;
            if (hp_count == 0) r.status = ST_EMPTY;
            else begin
                mv = hp_slot[1];
                lv = hp_slot[hp_count];
                r.vertex = mv;
                r.key = hp_key[mv];
                hp_slot[1] = lv;
                hp_pos[lv] = 11'd1;
                hp_count--;
                hp_pos[mv] = '0;
                heap_down(1);
            end
        end else begin
            if (hp_pos[op.vertex] != 0) begin
                r.status = ST_PRESENT;
                r.key = hp_key[op.vertex];
            end else if (hp_count >= MAX_VERTICES) r.status = ST_FULL;
            else begin
                hp_count++;
                hp_slot[hp_count] = op.vertex;
                hp_pos[op.vertex] = 11'(hp_count);
                hp_key[op.vertex] = op.key;
                r.key = op.key;
                heap_up(hp_count);
            end
        end
        r.entries = 11'(hp_count);
        return r;
    endfunction

    function automatic void push_op(logic [1:0] m, logic [9:0] v, logic [31:0] k);
        t_op op;
        op.mode = m;
        op.vertex = v;
        op.key = k;
        pending_ops.push_back(op);
    endfunction

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("indexed_min_heap_priority_queue_unit verification failed");
        $finish;
    end

    function automatic bit idle_now();
        return (calm == 0) && ($urandom_range(99) < 30);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 0;
            i_mode      <= '0;
            i_vertex_id <= '0;
            i_key_value <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(heap_apply({i_mode, i_vertex_id, i_key_value}));
                void'(pending_ops.pop_front());
            end
            if ((!i_in_valid || o_in_ready)) begin
                if (pending_ops.size() > (i_in_valid && o_in_ready ? 0 : 0) &&
                    !(i_in_valid && o_in_ready && pending_ops.size() == 0) && !idle_now()) begin
                    i_in_valid  <= 1;
                    i_mode      <= pending_ops[0].mode;
                    i_vertex_id <= pending_ops[0].vertex;
                    i_key_value <= pending_ops[0].key;
                end else begin
                    i_in_valid <= 0;
                end
            end
            if (calm > 0) calm <= calm - 1;
            else if ($urandom_range(9999) < 3) calm <= 3000;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            i_out_ready <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result vertex %0d", $time, o_out_vertex);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (e.vertex !== o_out_vertex) begin
                        $display("%0t: vertex exp %0d got %0d", $time, e.vertex, o_out_vertex);
                        errors++;
                    end
                    if (e.key !== o_out_key) begin
                        $display("%0t: key exp %0h got %0h", $time, e.key, o_out_key);
                        errors++;
                    end
                    if (e.status !== o_status) begin
                        $display("%0t: status exp %0d got %0d", $time, e.status, o_status);
                        errors++;
                    end
                    if (e.entries !== o_entries_after) begin
                        $display("%0t: entries exp %0d got %0d", $time, e.entries,
                                 o_entries_after);
                        errors++;
                    end
                end
            end
            i_out_ready <= !idle_now();
        end
    end

    initial begin
        int v, m;
        logic [31:0] k;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            hp_pos[i] = 0;
            hp_key[i] = 0;
            hp_slot[i+1] = 0;
        end
        hp_count = 0;
        i_rst_n = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: empty delete, extremes, ties, rejects, mode alias
        push_op(MODE_DELETE, 10'h3ff, 32'hffffffff);
        push_op(MODE_DECREASE, 10'd5, 32'd0);
        push_op(MODE_INSERT, 10'd0, 32'hffffffff);
        push_op(MODE_INSERT, 10'h3ff, 32'd0);
        push_op(MODE_INSERT, 10'd0, 32'd7);
        push_op(MODE_INSERT, 10'd1, 32'd0);
        push_op(MODE_INSERT, 10'd2, 32'd0);
        push_op(MODE_INSERT, 10'd3, 32'h80000000);
        push_op(MODE_DECREASE, 10'd3, 32'h80000000);
        push_op(MODE_DECREASE, 10'd3, 32'hffffffff);
        push_op(MODE_DECREASE, 10'd0, 32'd5);
        push_op(MODE_ALIAS, 10'd3, 32'd0);
        push_op(MODE_ALIAS, 10'd9, 32'd1);
        for (int i = 0; i < 7; i++) push_op(MODE_DELETE, 10'h155, 32'h55555555);

        // random mix over a small pool so hits are common
        for (int i = 0; i < 680; i++) begin
            m = $urandom_range(99);
            v = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(63);
            k = ($urandom_range(1) == 0) ? $urandom_range(15) : $urandom;
            if (m < 40) push_op(MODE_INSERT, v[9:0], k);
            else if (m < 70) push_op(MODE_DELETE, 10'($urandom), $urandom);
            else push_op($urandom_range(1) ? MODE_DECREASE : MODE_ALIAS, v[9:0], k);
        end
        for (int i = 0; i < 200; i++) push_op(MODE_DELETE, 10'($urandom), $urandom);

        wait (pending_ops.size() == 0 && expected_results.size() == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("indexed_min_heap_priority_queue_unit verification clean");
        else
            $display("indexed_min_heap_priority_queue_unit verification failed");
        $finish;
    end
endmodule

FILE: indexed_min_heap_priority_queue_unit.f
hw/rtl/imhpq_pkg.sv
hw/rtl/imhpq_ram.sv
hw/rtl/indexed_min_heap_priority_queue_unit.sv
dv/tb_indexed_min_heap_priority_queue_unit.sv
